// File: sv/msp_pkg.sv
// Shared types, byte codes and command lookup for the MSP request frame parser.
package msp_pkg;

  localparam logic [7:0] START_BYTE     = 8'h24;  // '$'
  localparam logic [7:0] PREAMBLE_BYTE  = 8'h4D;  // 'M'
  localparam logic [7:0] DIR_IN_BYTE    = 8'h3C;  // '<'
  localparam logic [7:0] CMD_API_VERSION     = 8'd1;
  localparam logic [7:0] CMD_SET_PASSTHROUGH = 8'd245;

  localparam logic RK_PAYLOAD   = 1'b0;
  localparam logic RK_FRAME_END = 1'b1;

  localparam logic [1:0] ST_OK           = 2'd0;
  localparam logic [1:0] ST_BAD_PREAMBLE = 2'd1;
  localparam logic [1:0] ST_BAD_DIR      = 2'd2;
  localparam logic [1:0] ST_BAD_CHECKSUM = 2'd3;

  typedef struct packed {
    logic       kind;
    logic [7:0] payload_byte;
    logic [7:0] byte_index;
    logic [7:0] command_id;
    logic [7:0] payload_size;
    logic [1:0] status;
    logic       supported;
    logic       passthrough_active;
  } msp_result_t;

  function automatic logic is_supported(input logic [7:0] cmd);
    logic hit;
    begin
      case (cmd) inside
        [8'd1:8'd5], 8'd36, 8'd101, 8'd104, 8'd105, 8'd108,
        8'd119, 8'd130, 8'd160, 8'd214, 8'd245: hit = 1'b1;
        default: hit = 1'b0;
      endcase
      return hit;
    end
  endfunction

endpackage

// File: sv/msp_skid.sv
// Two-entry output stage: result register plus skid register.
module msp_skid
  import msp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  msp_result_t push_data,
  output logic        full,
  output logic        out_valid,
  input  logic        out_stall,
  output msp_result_t out_data
);

  logic        skid_valid;
  msp_result_t skid_data;
  logic        drain;

  assign drain = out_valid && !out_stall;
  assign full  = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (drain) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid || drain) begin
        out_data  <= push_data;
        out_valid <= 1'b1;
      end else begin
        skid_data  <= push_data;
        skid_valid <= 1'b1;
      end
    end else if (drain) begin
      out_valid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_skid_implies_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held while result register empty");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("item pushed into a full output stage");

  a_stalled_result_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");
`endif

endmodule

// File: sv/msp_request_frame_parser.sv
// Top level: MSP v1 request frame parser with registered result output.
// One received byte is taken per item, and the block accepts a byte in every
// cycle: the frame state and running checksum update on each accepted byte, and
// results pass through a two-entry output stage, so input stalls only when
// both the result register and the skid register hold results that the
// receiver has not taken. Payload bytes come out as they arrive (tentative
// until the frame end); the checksum byte yields one frame-end result with
// status, command support and the passthrough flag. Bytes outside a frame
// other than '$' produce nothing; the parser returns to waiting after every
// checksum byte.
module msp_request_frame_parser
  import msp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       kind,
  output logic [7:0] payload_byte,
  output logic [7:0] byte_index,
  output logic [7:0] command_id,
  output logic [7:0] payload_size,
  output logic [1:0] status,
  output logic       supported,
  output logic       passthrough_active
);

  typedef enum logic [2:0] {
    PH_WAIT, PH_PREAMBLE, PH_DIRECTION, PH_SIZE, PH_COMMAND, PH_DATA, PH_CHECK
  } phase_t;

  phase_t      phase, phase_next;
  logic [7:0]  second_preamble, direction_byte, size_byte, command_byte;
  logic [7:0]  bytes_seen, running_xor;
  logic        passthrough_flag, passthrough_flag_next;
  logic        accept;
  logic        res_push;
  msp_result_t res;
  msp_result_t res_out;
  logic [1:0]  frame_status;
  logic [8:0]  seen_inc;
  logic        skid_full;

  assign accept   = in_valid && !in_stall;
  assign in_stall = skid_full;
  assign seen_inc = {1'b0, bytes_seen} + 9'd1;

  always_comb begin
    if (second_preamble != PREAMBLE_BYTE) begin
      frame_status = ST_BAD_PREAMBLE;
    end else if (direction_byte != DIR_IN_BYTE) begin
      frame_status = ST_BAD_DIR;
    end else if (rx_byte != running_xor) begin
      frame_status = ST_BAD_CHECKSUM;
    end else begin
      frame_status = ST_OK;
    end
  end

  always_comb begin
    phase_next            = phase;
    passthrough_flag_next = passthrough_flag;
    res_push              = 1'b0;
    res.kind               = RK_PAYLOAD;
    res.payload_byte       = 8'd0;
    res.byte_index         = 8'd0;
    res.command_id         = command_byte;
    res.payload_size       = size_byte;
    res.status             = ST_OK;
    res.supported          = is_supported(command_byte);
    res.passthrough_active = passthrough_flag;
    case (phase)
      PH_PREAMBLE:  phase_next = PH_DIRECTION;
      PH_DIRECTION: phase_next = PH_SIZE;
      PH_SIZE:      phase_next = PH_COMMAND;
      PH_COMMAND:   phase_next = (size_byte != 8'd0) ? PH_DATA : PH_CHECK;
      PH_DATA: begin
        res_push         = 1'b1;
        res.payload_byte = rx_byte;
        res.byte_index   = bytes_seen;
        if (seen_inc >= {1'b0, size_byte}) begin
          phase_next = PH_CHECK;
        end
      end
      PH_CHECK: begin
        // Only a clean frame may set or clear passthrough.
        if (frame_status == ST_OK) begin
          if (command_byte == CMD_SET_PASSTHROUGH) begin
            passthrough_flag_next = 1'b1;
          end else if (command_byte == CMD_API_VERSION) begin
            passthrough_flag_next = 1'b0;
          end
        end
        res_push               = 1'b1;
        res.kind               = RK_FRAME_END;
        res.status             = frame_status;
        res.passthrough_active = passthrough_flag_next;
        phase_next             = PH_WAIT;
      end
      default: phase_next = (rx_byte == START_BYTE) ? PH_PREAMBLE : PH_WAIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_WAIT;
      passthrough_flag <= 1'b0;
      second_preamble  <= 8'd0;
      direction_byte   <= 8'd0;
      size_byte        <= 8'd0;
      command_byte     <= 8'd0;
      bytes_seen       <= 8'd0;
      running_xor      <= 8'd0;
    end else if (accept) begin
      phase            <= phase_next;
      passthrough_flag <= passthrough_flag_next;
      case (phase)
        PH_PREAMBLE:  second_preamble <= rx_byte;
        PH_DIRECTION: direction_byte  <= rx_byte;
        PH_SIZE: begin
          size_byte   <= rx_byte;
          running_xor <= rx_byte;
        end
        PH_COMMAND: begin
          command_byte <= rx_byte;
          running_xor  <= running_xor ^ rx_byte;
          bytes_seen   <= 8'd0;
        end
        PH_DATA: begin
          running_xor <= running_xor ^ rx_byte;
          bytes_seen  <= seen_inc[7:0];
        end
        default: ;
      endcase
    end
  end

  msp_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (accept && res_push),
    .push_data (res),
    .full      (skid_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (res_out)
  );

  assign kind               = res_out.kind;
  assign payload_byte       = res_out.payload_byte;
  assign byte_index         = res_out.byte_index;
  assign command_id         = res_out.command_id;
  assign payload_size       = res_out.payload_size;
  assign status             = res_out.status;
  assign supported          = res_out.supported;
  assign passthrough_active = res_out.passthrough_active;

`ifndef SYNTHESIS
  a_payload_status_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == RK_PAYLOAD |-> status == ST_OK)
    else $error("payload item carries a frame status");

  a_index_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == RK_PAYLOAD |-> byte_index < payload_size)
    else $error("payload index beyond declared size");

  a_flag_only_on_frame_end: assert property (@(posedge clk) disable iff (rst)
    !(accept && phase == PH_CHECK) |=> passthrough_flag == $past(passthrough_flag))
    else $error("passthrough flag changed outside a frame end");

  a_start_detect: assert property (@(posedge clk) disable iff (rst)
    accept && phase == PH_WAIT && rx_byte == START_BYTE |=> phase == PH_PREAMBLE)
    else $error("start byte not taken");
`endif

endmodule

// File: test/msp_request_frame_parser_tb.sv
// Self-checking testbench for the MSP request frame parser: directed frames, then random traffic.
`timescale 1ns / 100ps

module msp_request_frame_parser_tb
  import msp_pkg::*;
();

  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 12;
  localparam int FRAME_BYTES  = 600;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam int LIMIT_CYCLES = 200000;
  localparam int MAX_PRINTS   = 40;

  typedef enum logic [2:0] {
    PH_IDLE, PH_SYNC2, PH_DIR, PH_LEN, PH_CMD, PH_BODY, PH_SUM
  } parse_phase_t;

  typedef struct {
    logic [7:0]  data;
    bit          typed;
    msp_result_t want;
  } stim_row_t;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] rx_byte;
  logic       out_valid;
  logic       out_stall;
  logic       kind;
  logic [7:0] payload_byte;
  logic [7:0] byte_index;
  logic [7:0] command_id;
  logic [7:0] payload_size;
  logic [1:0] status;
  logic       supported;
  logic       passthrough_active;

  msp_request_frame_parser DUT (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .rx_byte            (rx_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .kind               (kind),
    .payload_byte       (payload_byte),
    .byte_index         (byte_index),
    .command_id         (command_id),
    .payload_size       (payload_size),
    .status             (status),
    .supported          (supported),
    .passthrough_active (passthrough_active)
  );

  stim_row_t   stim_rows[$];
  msp_result_t expected_results[$];
  int          frame_bytes;
  int          accepted_count;
  int          error_count;
  int          cycle_count;
  bit          hold_rx;

  // Parser mirror
  parse_phase_t ps_phase;
  logic [7:0]   ps_pre;
  logic [7:0]   ps_dir;
  logic [7:0]   ps_len;
  logic [7:0]   ps_cmd;
  logic [7:0]   ps_count;
  logic [7:0]   ps_sum;
  logic         ps_passthru;

  stim_row_t   in_row;
  msp_result_t in_res;
  msp_result_t out_want;

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  function automatic logic cmd_known(input logic [7:0] c);
    return (c >= 8'd1 && c <= 8'd5) || c == 8'd36 || c == 8'd101 || c == 8'd104 ||
           c == 8'd105 || c == 8'd108 || c == 8'd119 || c == 8'd130 ||
           c == 8'd160 || c == 8'd214 || c == 8'd245;
  endfunction

  // Advance the mirror by one byte; return 1 when the byte yields a result.
  function automatic bit parse_byte(input logic [7:0] b, output msp_result_t r);
    bit         hit;
    logic [1:0] st;
    hit = 1'b0;
    r = '0;
    case (ps_phase)
      PH_SYNC2: begin
        ps_pre = b;
        ps_phase = PH_DIR;
      end
      PH_DIR: begin
        ps_dir = b;
        ps_phase = PH_LEN;
      end
      PH_LEN: begin
        ps_len = b;
        ps_sum = b;
        ps_phase = PH_CMD;
      end
      PH_CMD: begin
        ps_cmd = b;
        ps_sum = ps_sum ^ b;
        ps_count = 8'd0;
        ps_phase = (ps_len != 8'd0) ? PH_BODY : PH_SUM;
      end
      PH_BODY: begin
        r.kind = RK_PAYLOAD;
        r.payload_byte = b;
        r.byte_index = ps_count;
        ps_sum = ps_sum ^ b;
        ps_count = ps_count + 8'd1;
        if (ps_count >= ps_len) ps_phase = PH_SUM;
        hit = 1'b1;
      end
      PH_SUM: begin
        if (ps_pre != PREAMBLE_BYTE) st = ST_BAD_PREAMBLE;
        else if (ps_dir != DIR_IN_BYTE) st = ST_BAD_DIR;
        else if (b != ps_sum) st = ST_BAD_CHECKSUM;
        else st = ST_OK;
        // Only a clean frame may touch the passthrough flag
        if (st == ST_OK) begin
          if (ps_cmd == CMD_SET_PASSTHROUGH) ps_passthru = 1'b1;
          else if (ps_cmd == CMD_API_VERSION) ps_passthru = 1'b0;
        end
        r.kind = RK_FRAME_END;
        r.status = st;
        ps_phase = PH_IDLE;
        hit = 1'b1;
      end
      default: begin
        ps_phase = (b == START_BYTE) ? PH_SYNC2 : PH_IDLE;
      end
    endcase
    r.command_id = ps_cmd;
    r.payload_size = ps_len;
    r.supported = cmd_known(ps_cmd);
    r.passthrough_active = ps_passthru;
    return hit;
  endfunction

  function automatic msp_result_t frame_end(input logic [7:0] cmd, input logic [7:0] len,
                                            input logic [1:0] st, input logic sup,
                                            input logic pt);
    msp_result_t r;
    r = '0;
    r.kind = RK_FRAME_END;
    r.command_id = cmd;
    r.payload_size = len;
    r.status = st;
    r.supported = sup;
    r.passthrough_active = pt;
    return r;
  endfunction

  function automatic int draw_pause(input int pace);
    case (pace)
      0: return 0;
      1: return $urandom_range(0, 16);
      default: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 16) : 0;
    endcase
  endfunction

  function automatic logic [7:0] pick_known_cmd();
    case ($urandom_range(0, 14))
      0: return 8'd1;
      1: return 8'd2;
      2: return 8'd3;
      3: return 8'd4;
      4: return 8'd5;
      5: return 8'd36;
      6: return 8'd101;
      7: return 8'd104;
      8: return 8'd105;
      9: return 8'd108;
      10: return 8'd119;
      11: return 8'd130;
      12: return 8'd160;
      13: return 8'd214;
      default: return 8'd245;
    endcase
  endfunction

  task automatic flag_error(input string msg);
    if (error_count < MAX_PRINTS) $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want) flag_error($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  task automatic add_row(input logic [7:0] data, input bit typed, input msp_result_t want);
    stim_row_t row;
    row.data = data;
    row.typed = typed;
    row.want = want;
    stim_rows.push_back(row);
  endtask

  task automatic add_plain(input logic [7:0] data);
    add_row(data, 1'b0, '0);
  endtask

  // One random frame, mostly well formed, with optional leading noise.
  task automatic queue_frame(input int frame_no);
    int         noise;
    int         fault;
    int         pick;
    logic [7:0] len;
    logic [7:0] cmd;
    logic [7:0] pre;
    logic [7:0] dir;
    logic [7:0] sum;
    logic [7:0] data;
    if ($urandom_range(0, 3) == 0) begin
      noise = $urandom_range(1, 3);
      repeat (noise) begin
        data = 8'($urandom_range(0, 255));
        if (data == START_BYTE) data = data ^ 8'h01;
        add_plain(data);
      end
    end
    if (frame_no == 5) len = 8'd255;
    else if ($urandom_range(0, 39) == 0) len = 8'($urandom_range(9, 254));
    else len = 8'($urandom_range(0, 8));
    pick = $urandom_range(0, 9);
    if (pick < 3) cmd = pick_known_cmd();
    else if (pick == 3) cmd = CMD_SET_PASSTHROUGH;
    else if (pick == 4) cmd = CMD_API_VERSION;
    else cmd = 8'($urandom_range(0, 255));
    fault = $urandom_range(0, 9);
    pre = PREAMBLE_BYTE;
    dir = DIR_IN_BYTE;
    if (fault == 0) begin
      pre = 8'($urandom_range(0, 255));
      if (pre == PREAMBLE_BYTE) pre = pre ^ 8'h80;
      if ($urandom_range(0, 1) == 1) dir = 8'($urandom_range(0, 255));
    end else if (fault == 1) begin
      dir = 8'($urandom_range(0, 255));
      if (dir == DIR_IN_BYTE) dir = dir ^ 8'h40;
    end
    add_plain(START_BYTE);
    add_plain(pre);
    add_plain(dir);
    add_plain(len);
    add_plain(cmd);
    sum = len ^ cmd;
    for (int i = 0; i < len; i++) begin
      data = 8'($urandom_range(0, 255));
      sum = sum ^ data;
      add_plain(data);
    end
    if (fault == 2) sum = sum ^ 8'($urandom_range(1, 255));
    add_plain(sum);
    frame_bytes += 6 + len;
  endtask

  task automatic build_stimulus();
    int frame_no;
    // Noise, then a clean zero-size passthrough request
    add_plain(8'h00);
    add_plain(START_BYTE);
    add_plain(PREAMBLE_BYTE);
    add_plain(DIR_IN_BYTE);
    add_plain(8'h00);
    add_plain(CMD_SET_PASSTHROUGH);
    add_row(8'hF5, 1'b1, frame_end(CMD_SET_PASSTHROUGH, 8'h00, ST_OK, 1'b1, 1'b1));
    // Bad preamble wins over bad direction and bad checksum; flag holds
    add_plain(START_BYTE);
    add_plain(8'h58);
    add_plain(8'h3E);
    add_plain(8'h00);
    add_plain(CMD_API_VERSION);
    add_row(8'h00, 1'b1, frame_end(CMD_API_VERSION, 8'h00, ST_BAD_PREAMBLE, 1'b1, 1'b1));
    // Bad direction wins over bad checksum
    add_plain(START_BYTE);
    add_plain(PREAMBLE_BYTE);
    add_plain(8'h3E);
    add_plain(8'h00);
    add_plain(8'hFF);
    add_row(8'h00, 1'b1, frame_end(8'hFF, 8'h00, ST_BAD_DIR, 1'b0, 1'b1));
    // Start byte carried as payload, then a wrong checksum
    add_plain(START_BYTE);
    add_plain(PREAMBLE_BYTE);
    add_plain(DIR_IN_BYTE);
    add_plain(8'h01);
    add_plain(8'h00);
    add_plain(START_BYTE);
    add_row(8'h00, 1'b1, frame_end(8'h00, 8'h01, ST_BAD_CHECKSUM, 1'b0, 1'b1));
    add_plain(8'hFF);
    frame_no = 0;
    frame_bytes = 0;
    while (frame_bytes < FRAME_BYTES) begin
      queue_frame(frame_no);
      frame_no++;
    end
  endtask

  // Sender
  initial begin : sender
    int pace;
    int pause;
    clk = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    rx_byte = 8'h00;
    accepted_count = 0;
    error_count = 0;
    ps_phase = PH_IDLE;
    ps_pre = 8'h00;
    ps_dir = 8'h00;
    ps_len = 8'h00;
    ps_cmd = 8'h00;
    ps_count = 8'h00;
    ps_sum = 8'h00;
    ps_passthru = 1'b0;
    pace = 0;
    build_stimulus();
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;
    for (int n = 0; n < stim_rows.size(); n++) begin
      if (n % 40 == 0) pace = $urandom_range(0, 2);
      pause = draw_pause(pace);
      @(negedge clk);
      if (pause > 0) begin
        in_valid <= 1'b0;
        repeat (pause) @(negedge clk);
      end
      in_valid <= 1'b1;
      rx_byte <= stim_rows[n].data;
      do @(posedge clk); while (in_stall);
    end
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("msp_request_frame_parser_tb OK");
    end else begin
      $display("msp_request_frame_parser_tb NOT OK");
    end
    $finish;
  end

  // Receiver
  initial begin : receiver
    int pace;
    int pause;
    int n;
    out_stall = 1'b1;
    pace = 0;
    n = 0;
    wait (!rst);
    forever begin
      if (n % 40 == 0) pace = $urandom_range(0, 2);
      pause = draw_pause(pace);
      n++;
      @(negedge clk);
      if (pause > 0 || hold_rx) begin
        out_stall <= 1'b1;
        repeat (pause) @(negedge clk);
        while (hold_rx) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Long receiver hold-off while the sender keeps offering items
  initial begin : backpressure
    int held;
    hold_rx = 1'b0;
    held = 0;
    wait (accepted_count >= 200);
    @(posedge clk);
    hold_rx = 1'b1;
    while (held < HOLD_CYCLES) begin
      @(posedge clk);
      held++;
    end
    hold_rx = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      in_row = stim_rows[accepted_count];
      if (parse_byte(rx_byte, in_res)) begin
        if (in_row.typed) in_res = in_row.want;
        expected_results.push_back(in_res);
      end
      accepted_count++;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        flag_error("result with no item pending");
      end else begin
        out_want = expected_results.pop_front();
        check_field("kind", 8'(kind), 8'(out_want.kind));
        check_field("payload_byte", payload_byte, out_want.payload_byte);
        check_field("byte_index", byte_index, out_want.byte_index);
        check_field("command_id", command_id, out_want.command_id);
        check_field("payload_size", payload_size, out_want.payload_size);
        check_field("status", 8'(status), 8'(out_want.status));
        check_field("supported", 8'(supported), 8'(out_want.supported));
        check_field("passthrough_active", 8'(passthrough_active),
                    8'(out_want.passthrough_active));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("msp_request_frame_parser_tb NOT OK");
      $finish;
    end
  end

  initial cycle_count = 0;

endmodule
